// ===== rtl/cses_pkg.sv =====
// Shared types and constants for the CAN signal extract and scale block.
// Holds the register map, item structs and stage payload types.
// No dependencies.
package cses_pkg;

  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int          FLT_BIAS_SHIFT = 150 - FRACTION_BITS;

  localparam logic [31:0] FULL_MASK = 32'hFFFF_FFFF;
  localparam logic signed [31:0] PHYS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PHYS_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGNAL_ID    = 3'd0,
    REG_BYTE_ORDER   = 3'd1,
    REG_START_BIT    = 3'd2,
    REG_BIT_COUNT    = 3'd3,
    REG_VALUE_TYPE   = 3'd4,
    REG_SCALE_FACTOR = 3'd5,
    REG_SCALE_OFFSET = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    VT_UNSIGNED = 2'd0,
    VT_SIGNED   = 2'd1,
    VT_FLOAT    = 2'd2,
    VT_NONE     = 2'd3
  } value_type_e;

  typedef struct packed {
    logic [10:0]        signal_id;
    logic               byte_order;
    logic [5:0]         start_bit;
    logic [5:0]         bit_count;
    value_type_e        value_type;
    logic signed [31:0] scale_factor;
    logic signed [31:0] scale_offset;
  } cfg_t;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [3:0]  length;
    logic [63:0] payload;
  } in_item_t;

  typedef struct packed {
    logic               matched;
    logic [31:0]        raw_field;
    logic signed [31:0] physical_value;
  } out_item_t;

  typedef struct packed {
    logic        matched;
    logic [63:0] word;
  } asm_t;

  typedef struct packed {
    logic               matched;
    logic [31:0]        raw;
    logic signed [32:0] op;
  } ext_t;

  typedef struct packed {
    logic               matched;
    logic [31:0]        raw;
    logic signed [64:0] prod;
    logic signed [31:0] flt;
  } mul_t;

endpackage

// ===== rtl/can_signal_extract_scale.sv =====
// CAN signal extract and scale: top level with the register file and the
// four-stage pipeline. Depends on cses_pkg, cses_assemble, cses_extract, cses_scale.
//
// One received standard CAN frame enters per cycle unless backpressure
// holds the input, and yields exactly one result: matched, the raw bit
// field, and a saturated Q16.16 physical value. A frame whose identifier
// differs from signal_id, or any frame while value_type selects the unused
// code, yields an all-zero result. The block sustains one transfer per
// cycle in each direction while out_ready_i is high. Each result passes
// through the register stages in order: byte assembly, field extraction,
// 33x32 multiply with float conversion, and offset add with saturation into
// the output register. Backpressure stalls the stages that are full while
// empty stages keep filling. Write registers only while no frame is in flight.
module can_signal_extract_scale import cses_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  cfg_t cfg_q;
  logic asm_valid, asm_ready;
  asm_t asm_data;
  logic ext_valid, ext_ready;
  ext_t ext_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.signal_id    <= 11'd0;
      cfg_q.byte_order   <= 1'b0;
      cfg_q.start_bit    <= 6'd0;
      cfg_q.bit_count    <= 6'd16;
      cfg_q.value_type   <= VT_UNSIGNED;
      cfg_q.scale_factor <= 32'sd65536;
      cfg_q.scale_offset <= 32'sd0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SIGNAL_ID:    cfg_q.signal_id    <= cfg_wdata_i[10:0];
        REG_BYTE_ORDER:   cfg_q.byte_order   <= cfg_wdata_i[0];
        REG_START_BIT:    cfg_q.start_bit    <= cfg_wdata_i[5:0];
        REG_BIT_COUNT:    cfg_q.bit_count    <= cfg_wdata_i[5:0];
        REG_VALUE_TYPE:   cfg_q.value_type   <= value_type_e'(cfg_wdata_i[1:0]);
        REG_SCALE_FACTOR: cfg_q.scale_factor <= $signed(cfg_wdata_i);
        REG_SCALE_OFFSET: cfg_q.scale_offset <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  cses_assemble u_assemble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item_i),
    .valid_o (asm_valid),
    .ready_i (asm_ready),
    .data_o  (asm_data)
  );

  cses_extract u_extract (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (asm_valid),
    .ready_o (asm_ready),
    .data_i  (asm_data),
    .valid_o (ext_valid),
    .ready_i (ext_ready),
    .data_o  (ext_data)
  );

  cses_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (ext_valid),
    .ready_o (ext_ready),
    .data_i  (ext_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (out_item_o)
  );

endmodule

// ===== rtl/cses_assemble.sv =====
// Stage 1: identifier match and byte lane assembly into a 64-bit word.
// Depends on cses_pkg.
module cses_assemble import cses_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  output logic     valid_o,
  input  logic     ready_i,
  output asm_t     data_o
);

  logic       valid_q;
  asm_t       data_q, data_d;
  logic [3:0] len;
  logic [3:0] src [8];
  logic [3:0] pos [8];
  logic       hit [8];

  always_comb begin
    len = (item_i.length > 4'd8) ? 4'd8 : item_i.length;
    data_d.matched = (item_i.frame_id == cfg_i.signal_id) && (cfg_i.value_type != VT_NONE);
    for (int j = 0; j < 8; j++) begin
      if (cfg_i.byte_order == 1'b0) begin
        pos[j] = 4'(j);
        src[j] = 4'(j);
      end else begin
        pos[j] = 4'(j) ^ 4'd4;
        src[j] = len - 4'd1 - (4'(j) ^ 4'd4);
      end
      hit[j] = pos[j] < len;
      data_d.word[8*j +: 8] = hit[j] ? item_i.payload[{src[j][2:0], 3'b000} +: 8] : 8'd0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/cses_extract.sv =====
// Stage 2: bit field extraction, masking and sign extension of the operand.
// Depends on cses_pkg.
module cses_extract import cses_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  output logic ready_o,
  input  asm_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output ext_t data_o
);

  logic        valid_q;
  ext_t        data_q, data_d;
  logic [5:0]  cnt;
  logic [63:0] sh_word;
  logic [31:0] mask;
  logic [31:0] ext;
  logic        sign_bit;

  always_comb begin
    cnt      = (cfg_i.bit_count > 6'd32) ? 6'd32 : cfg_i.bit_count;
    sh_word  = data_i.word >> cfg_i.start_bit;
    mask     = cnt[5] ? FULL_MASK : ((32'd1 << cnt[4:0]) - 32'd1);
    data_d.matched = data_i.matched;
    data_d.raw     = sh_word[31:0] & mask;
    sign_bit = data_d.raw[cnt[4:0] - 5'd1];
    if ((cfg_i.value_type == VT_SIGNED) && (cnt != 6'd0) && !cnt[5] && sign_bit) begin
      ext = data_d.raw | ~mask;
    end else begin
      ext = data_d.raw;
    end
    if (cfg_i.value_type == VT_SIGNED) begin
      data_d.op = {ext[31], ext};
    end else begin
      data_d.op = {1'b0, data_d.raw};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/cses_f2fix.sv =====
// IEEE single to signed fixed point, truncating toward zero with saturation.
// Depends on cses_pkg.
module cses_f2fix import cses_pkg::*; (
  input  logic [31:0]        bits_i,
  output logic signed [31:0] fixed_o
);

  localparam logic signed [9:0] BIAS = 10'(FLT_BIAS_SHIFT);

  logic [7:0]        expo;
  logic [22:0]       frac;
  logic              neg;
  logic [23:0]       mant;
  logic signed [9:0] sh;
  logic [9:0]        nsh;
  logic [32:0]       mag;
  logic [32:0]       limit;
  logic [32:0]       neg_mag;
  logic              over;

  always_comb begin
    expo  = bits_i[30:23];
    frac  = bits_i[22:0];
    neg   = bits_i[31];
    mant  = {expo != 8'd0, frac};
    sh    = $signed({2'b00, expo}) - BIAS;
    nsh   = 10'(-sh);
    limit = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    over  = 1'b0;
    mag   = '0;
    if (sh > 10'sd8) begin
      over = 1'b1;
    end else if (!sh[9]) begin
      mag = {9'd0, mant} << sh[3:0];
    end else if (nsh < 10'd24) begin
      mag = {9'd0, mant >> nsh[4:0]};
    end
    if (over || (mag > limit)) begin
      mag = limit;
    end
    neg_mag = ~mag + 33'd1;
    if (expo == 8'hFF) begin
      if (frac != 23'd0) begin
        fixed_o = '0;
      end else begin
        fixed_o = neg ? PHYS_MIN : PHYS_MAX;
      end
    end else begin
      fixed_o = neg ? $signed(neg_mag[31:0]) : $signed(mag[31:0]);
    end
  end

endmodule

// ===== rtl/cses_scale.sv =====
// Stages 3 and 4: multiply and float conversion, then offset, saturation
// and the output register. Depends on cses_pkg and cses_f2fix.
module cses_scale import cses_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      valid_i,
  output logic      ready_o,
  input  ext_t      data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output out_item_t item_o
);

  localparam logic signed [65:0] SUM_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SUM_MIN = -66'sd2147483648;

  logic               mul_valid_q, out_valid_q;
  mul_t               mul_q, mul_d;
  out_item_t          out_q, out_d;
  logic               out_ready;
  logic signed [31:0] flt;
  logic signed [65:0] sum;
  logic signed [31:0] sat;

  cses_f2fix u_f2fix (
    .bits_i  (data_i.raw),
    .fixed_o (flt)
  );

  always_comb begin
    mul_d.matched = data_i.matched;
    mul_d.raw     = data_i.raw;
    mul_d.prod    = $signed(data_i.op) * $signed(cfg_i.scale_factor);
    mul_d.flt     = flt;
  end

  always_comb begin
    sum = $signed(mul_q.prod) + $signed(cfg_i.scale_offset);
    if (sum > SUM_MAX) begin
      sat = PHYS_MAX;
    end else if (sum < SUM_MIN) begin
      sat = PHYS_MIN;
    end else begin
      sat = $signed(sum[31:0]);
    end
    if (mul_q.matched) begin
      out_d.matched        = 1'b1;
      out_d.raw_field      = mul_q.raw;
      out_d.physical_value = (cfg_i.value_type == VT_FLOAT) ? mul_q.flt : sat;
    end else begin
      out_d = '0;
    end
  end

  assign out_ready = !out_valid_q || ready_i;
  assign ready_o   = !mul_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        mul_valid_q <= valid_i;
      end
      if (out_ready) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      mul_q <= mul_d;
    end
    if (out_ready) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign item_o  = out_q;

endmodule

// ===== rtl/cses_checker.sv =====
// Port-level checks for can_signal_extract_scale, attached by bind.
// Depends on cses_pkg.
module cses_checker import cses_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output transfer changed while stalled");

  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.matched |->
      (out_item_o.raw_field == 32'd0) && (out_item_o.physical_value == 32'sd0))
    else $error("unmatched result carries nonzero fields");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_o)
    else $error("accepted transfer did not reach the output in four cycles");

endmodule

bind can_signal_extract_scale cses_checker u_cses_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
